FILE: src/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/esc_pkg.sv
// Types, constants and microcode for the epoch seconds to calendar converter.
package esc_pkg;

	localparam logic [11:0] EpochYear     = 12'd1970;
	localparam logic [11:0] CenturyNoLeap = 12'd2100;
	localparam logic [3:0]  MonthJan      = 4'd1;
	localparam logic [3:0]  MonthFeb      = 4'd2;
	localparam logic [3:0]  MonthDec      = 4'd12;

	// Reciprocals: quotient = (dividend * recip) >> shift, exact over each step's range.
	localparam logic [31:0] Recip60 = 32'h8888_8889;
	localparam logic [5:0]  Shift60 = 6'd37;
	localparam logic [31:0] Recip24 = 32'hAAAA_AAAB;
	localparam logic [5:0]  Shift24 = 6'd36;
	// Day counts stay below 2^16, so a short reciprocal is enough for /7.
	localparam logic [31:0] Recip7  = 32'd74899;
	localparam logic [5:0]  Shift7  = 6'd19;

	typedef enum logic [3:0] {
		OP_LOAD,
		OP_DIV_MUL,
		OP_DIV_REM,
		OP_SAVE_SEC,
		OP_SAVE_MIN,
		OP_SAVE_HOUR,
		OP_SAVE_WDAY,
		OP_YEAR,
		OP_MONTH,
		OP_DONE
	} op_t;

	// Jump taken when the condition holds, otherwise fall through to pc + 1.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_YEAR_LONG,
		C_MONTH_LONG
	} cond_t;

	typedef logic [3:0] pc_t;

	typedef struct packed {
		op_t         op;
		cond_t       cond;
		pc_t         target;
		logic [5:0]  divisor;
		logic [5:0]  shift;
		logic [31:0] recip;
	} uword_t;

	localparam pc_t PcIdle = 4'd0;

	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		w = '{op: OP_DONE, cond: C_ALWAYS, target: PcIdle, divisor: 6'd1, shift: 6'd0,
			recip: 32'd0};
		case (pc)
			4'd0:  w = '{OP_LOAD,      C_NO_START,   4'd0,  6'd1,  6'd0,    32'd0};
			4'd1:  w = '{OP_DIV_MUL,   C_NEVER,      4'd0,  6'd60, Shift60, Recip60};
			4'd2:  w = '{OP_DIV_REM,   C_NEVER,      4'd0,  6'd60, Shift60, Recip60};
			4'd3:  w = '{OP_SAVE_SEC,  C_NEVER,      4'd0,  6'd60, Shift60, Recip60};
			4'd4:  w = '{OP_DIV_MUL,   C_NEVER,      4'd0,  6'd60, Shift60, Recip60};
			4'd5:  w = '{OP_DIV_REM,   C_NEVER,      4'd0,  6'd60, Shift60, Recip60};
			4'd6:  w = '{OP_SAVE_MIN,  C_NEVER,      4'd0,  6'd60, Shift60, Recip60};
			4'd7:  w = '{OP_DIV_MUL,   C_NEVER,      4'd0,  6'd24, Shift24, Recip24};
			4'd8:  w = '{OP_DIV_REM,   C_NEVER,      4'd0,  6'd24, Shift24, Recip24};
			4'd9:  w = '{OP_SAVE_HOUR, C_NEVER,      4'd0,  6'd24, Shift24, Recip24};
			4'd10: w = '{OP_DIV_MUL,   C_NEVER,      4'd0,  6'd7,  Shift7,  Recip7};
			4'd11: w = '{OP_DIV_REM,   C_NEVER,      4'd0,  6'd7,  Shift7,  Recip7};
			4'd12: w = '{OP_SAVE_WDAY, C_NEVER,      4'd0,  6'd7,  Shift7,  Recip7};
			4'd13: w = '{OP_YEAR,      C_YEAR_LONG,  4'd13, 6'd1,  6'd0,    32'd0};
			4'd14: w = '{OP_MONTH,     C_MONTH_LONG, 4'd14, 6'd1,  6'd0,    32'd0};
			4'd15: w = '{OP_DONE,      C_ALWAYS,     4'd0,  6'd1,  6'd0,    32'd0};
			default: w = '{OP_DONE,    C_ALWAYS,     4'd0,  6'd1,  6'd0,    32'd0};
		endcase
		return w;
	endfunction

	// Years reachable here are 1970..2106: 2100 is the only multiple of four
	// in that span that is not a leap year.
	function automatic logic is_leap(input logic [11:0] y);
		return (y[1:0] == 2'b00) && (y != CenturyNoLeap);
	endfunction

	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		d = 5'd31;
		case (m)
			MonthFeb: d = leap ? 5'd29 : 5'd28;
			4'd4:     d = 5'd30;
			4'd6:     d = 5'd30;
			4'd9:     d = 5'd30;
			4'd11:    d = 5'd30;
			default:  d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

FILE: src/epoch_seconds_to_calendar.sv
// Top level: Unix seconds to local calendar date, time of day and weekday.
//
//  channel  | signals                              | handshake
//  ---------+--------------------------------------+-----------------------------
//  input    | epoch_seconds                        | start, taken when !busy
//  result   | second_of_minute .. weekday          | done, one-cycle strobe
//  config   | cfg_data (tz offset, hours)          | cfg_valid / cfg_ready
//
// From accept to done an item runs four constant divisions (/60, /60, /24, /7) of
// three steps each (reciprocal multiply, remainder, save), then the year and month walk.
// A new item may be accepted in the cycle done is high.
// Reset (arst_n low) clears the step counter, strobe and offset (offset = 0).
// The receiver cannot stall; results are valid only while done is high.
module epoch_seconds_to_calendar (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic signed [4:0] cfg_data,
	input  logic              start,
	output logic              busy,
	input  logic [31:0]       epoch_seconds,
	output logic              done,
	output logic [5:0]        second_of_minute,
	output logic [5:0]        minute_of_hour,
	output logic [4:0]        hour_of_day,
	output logic [4:0]        day_of_month,
	output logic [3:0]        month_number,
	output logic [11:0]       year_number,
	output logic [2:0]        weekday
);
	import esc_pkg::*;

	localparam logic signed [12:0] SecPerHour = 13'sd3600;

	pc_t               pc_q;
	logic              done_q;
	logic signed [4:0] tz_q;
	logic [31:0]       a_q;
	logic [31:0]       quo_q;
	logic [5:0]        rem_q;
	logic [15:0]       days_q;
	logic [11:0]       year_q;
	logic [3:0]        month_q;
	logic [5:0]        sec_q;
	logic [5:0]        min_q;
	logic [4:0]        hour_q;
	logic [4:0]        dom_q;
	logic [2:0]        wday_q;

	uword_t            uw;
	logic signed [17:0] tz_secs;
	logic [31:0]       sum;
	logic [63:0]       prod;
	logic              leap;
	logic [8:0]        ylen;
	logic [4:0]        mlen;
	logic              year_long;
	logic              month_long;
	logic              jump;

	assign uw = ucode(pc_q);

	assign tz_secs = 18'(tz_q) * 18'(SecPerHour);
	assign sum     = epoch_seconds + {{14{tz_secs[17]}}, tz_secs};

	// Division by a constant: multiply by the scaled reciprocal, keep the high bits.
	assign prod = {32'b0, a_q} * {32'b0, uw.recip};

	assign leap       = is_leap(year_q);
	assign ylen       = leap ? 9'd366 : 9'd365;
	assign mlen       = days_in_month(month_q, leap);
	assign year_long  = days_q >= {7'b0, ylen};
	assign month_long = (days_q >= {11'b0, mlen}) && (month_q != MonthDec);

	always_comb begin
		case (uw.cond)
			C_NEVER:      jump = 1'b0;
			C_ALWAYS:     jump = 1'b1;
			C_NO_START:   jump = !start;
			C_YEAR_LONG:  jump = year_long;
			C_MONTH_LONG: jump = month_long;
			default:      jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= PcIdle;
			done_q <= 1'b0;
			tz_q   <= '0;
		end else begin
			pc_q   <= jump ? uw.target : pc_q + 4'd1;
			done_q <= uw.op == OP_DONE;
			if (cfg_valid) begin
				tz_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LOAD: begin
				if (start) begin
					a_q <= sum;
				end
			end
			OP_DIV_MUL: begin
				quo_q <= 32'(prod >> uw.shift);
			end
			OP_DIV_REM: begin
				rem_q <= 6'(a_q - quo_q * {26'b0, uw.divisor});
			end
			OP_SAVE_SEC: begin
				sec_q <= rem_q;
				a_q   <= quo_q;
			end
			OP_SAVE_MIN: begin
				min_q <= rem_q;
				a_q   <= quo_q;
			end
			OP_SAVE_HOUR: begin
				hour_q <= rem_q[4:0];
				days_q <= quo_q[15:0];
				// 1970-01-01 was a Thursday: weekday = (days + 3) mod 7 + 1
				a_q    <= {16'b0, quo_q[15:0] + 16'd3};
			end
			OP_SAVE_WDAY: begin
				wday_q  <= rem_q[2:0] + 3'd1;
				year_q  <= EpochYear;
				month_q <= MonthJan;
			end
			OP_YEAR: begin
				if (year_long) begin
					days_q <= days_q - {7'b0, ylen};
					year_q <= year_q + 12'd1;
				end
			end
			OP_MONTH: begin
				if (month_long) begin
					days_q  <= days_q - {11'b0, mlen};
					month_q <= month_q + 4'd1;
				end
			end
			OP_DONE: begin
				dom_q <= 5'(days_q + 16'd1);
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready        = 1'b1;
	assign busy             = pc_q != PcIdle;
	assign done             = done_q;
	assign second_of_minute = sec_q;
	assign minute_of_hour   = min_q;
	assign hour_of_day      = hour_q;
	assign day_of_month     = dom_q;
	assign month_number     = month_q;
	assign year_number      = year_q;
	assign weekday          = wday_q;

endmodule

FILE: src/esc_checker.sv
// Port-level checker for the converter, bound to the top level.
`include "assert_macros.svh"

module esc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [4:0] hour_of_day,
	input logic [4:0] day_of_month,
	input logic [3:0] month_number,
	input logic [2:0] weekday
);

	logic fields_ok;

	assign fields_ok = (month_number >= 4'd1) && (month_number <= 4'd12) &&
		(day_of_month != 5'd0) && (hour_of_day < 5'd24) && (weekday != 3'd0);

	`ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")

	`ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

	`ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")

	`ASSERT_NOW(a_result_range, done, fields_ok, "result field out of range")

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);

FILE: tb/sv/tb_epoch_seconds_to_calendar.sv
// Self-checking testbench for the Unix seconds to calendar date converter.
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar;

	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned FirstYear   = 1970;
	localparam int unsigned CycleLimit  = 1000000;
	localparam int unsigned DrainCycles = 300;
	localparam int unsigned PhaseItems  = 133;

	typedef struct packed {
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  mday;
		logic [3:0]  month;
		logic [11:0] year;
		logic [2:0]  wday;
	} cal_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic signed [4:0] cfg_data      = '0;
	logic              start         = 1'b0;
	logic              busy;
	logic [31:0]       epoch_seconds = '0;
	logic              done;
	logic [5:0]        second_of_minute;
	logic [5:0]        minute_of_hour;
	logic [4:0]        hour_of_day;
	logic [4:0]        day_of_month;
	logic [3:0]        month_number;
	logic [11:0]       year_number;
	logic [2:0]        weekday;

	logic [31:0]       pending_secs[$];
	cal_t              expected_dates[$];
	logic signed [4:0] tz_hours    = '0;
	int unsigned       idle_pct    = 0;
	int unsigned       errors      = 0;
	int unsigned       cycles      = 0;
	int unsigned       converted   = 0;
	int unsigned       tz_settings = 0;
	int unsigned       year_lo     = 4095;
	int unsigned       year_hi     = 0;

	epoch_seconds_to_calendar u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.start            (start),
		.busy             (busy),
		.epoch_seconds    (epoch_seconds),
		.done             (done),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.day_of_month     (day_of_month),
		.month_number     (month_number),
		.year_number      (year_number),
		.weekday          (weekday)
	);

	always #5 clk = ~clk;

	// Local time for a timestamp: offset sum wraps mod 2^32, then a year and month walk.
	function automatic cal_t civil_time_of(input logic [31:0] secs, input logic signed [4:0] tz);
		logic [31:0] t;
		int unsigned days, yr, mo, ylen, mlen;
		bit leap;
		cal_t c;
		t = secs + 32'(int'(tz) * int'(SecsPerHour));
		c.second = 6'(t % 60);
		t = t / 60;
		c.minute = 6'(t % 60);
		t = t / 60;
		c.hour = 5'(t % 24);
		days = t / 24;
		// day 0 was a Thursday
		c.wday = 3'((days + 3) % 7 + 1);
		yr = FirstYear;
		forever begin
			leap = (yr % 400 == 0) || (yr % 4 == 0 && yr % 100 != 0);
			ylen = leap ? 366 : 365;
			if (days < ylen) break;
			days -= ylen;
			yr++;
		end
		mo = 1;
		forever begin
			case (mo)
				2: begin
					mlen = leap ? 29 : 28;
				end
				4, 6, 9, 11: begin
					mlen = 30;
				end
				default: begin
					mlen = 31;
				end
			endcase
			if (days < mlen || mo == 12) break;
			days -= mlen;
			mo++;
		end
		c.mday = 5'(days + 1);
		c.month = 4'(mo);
		c.year = 12'(yr);
		return c;
	endfunction

	// Mostly uniform, with extra weight near both ends of the range and near midnight.
	function automatic logic [31:0] pick_timestamp();
		logic [31:0] day_start;
		day_start = 32'($urandom_range(0, 49710)) * 32'd86400;
		case ($urandom_range(0, 9))
			5: begin
				return 32'($urandom_range(0, 200000));
			end
			6: begin
				return 32'hFFFF_FFFF - 32'($urandom_range(0, 200000));
			end
			7: begin
				return day_start + 32'($urandom_range(0, 2));
			end
			8: begin
				return day_start - 32'($urandom_range(1, 3));
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic wait_drained();
		while (pending_secs.size() != 0 || start || expected_dates.size() != 0)
			@(posedge clk);
	endtask

	// Offset changes only with the converter idle.
	task automatic write_offset(input logic signed [4:0] hours);
		wait_drained();
		cfg_data <= hours;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tz_settings++;
	endtask

	task automatic run_random(input logic signed [4:0] hours, input int unsigned pct);
		write_offset(hours);
		idle_pct = pct;
		repeat (PhaseItems) pending_secs.push_back(pick_timestamp());
	endtask

	// Driver: holds an item until it is taken, then moves on or idles.
	always @(posedge clk) begin
		if (arst_n && !(start && busy)) begin
			if (pending_secs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				start <= 1'b1;
				epoch_seconds <= pending_secs.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: result check first, since a new item may be taken in the done cycle.
	always @(posedge clk) begin : monitor
		cal_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_dates.size() == 0) begin
					$error("result with no item outstanding");
					errors++;
				end else begin
					want = expected_dates.pop_front();
					compare_field("second_of_minute", want.second, second_of_minute);
					compare_field("minute_of_hour", want.minute, minute_of_hour);
					compare_field("hour_of_day", want.hour, hour_of_day);
					compare_field("day_of_month", want.mday, day_of_month);
					compare_field("month_number", want.month, month_number);
					compare_field("year_number", want.year, year_number);
					compare_field("weekday", want.wday, weekday);
					converted++;
					if (want.year < year_lo) year_lo = want.year;
					if (want.year > year_hi) year_hi = want.year;
				end
			end
			if (cfg_valid && cfg_ready)
				tz_hours <= cfg_data;
			if (start && !busy)
				expected_dates.push_back(civil_time_of(epoch_seconds, tz_hours));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// UTC: epoch, minute/hour/day edges, leap days incl. 2000, non-leap 2100,
		// sign boundary of a 32-bit count, alternating bits, last second.
		write_offset(5'sd0);
		idle_pct = 0;
		pending_secs = '{32'd0, 32'd1, 32'd59, 32'd3599, 32'd86399, 32'd86400,
			32'd68169600, 32'd951782400, 32'd951868800, 32'd4107456000,
			32'd4107542400, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
			32'hAAAA_AAAA, 32'hFFFF_FFFF};

		// Most negative offset: small timestamps wrap below zero.
		write_offset(-5'sd16);
		pending_secs = '{32'd0, 32'd57599, 32'd57600};

		// Most positive offset: large timestamps wrap past the top.
		write_offset(5'sd15);
		pending_secs = '{32'hFFFF_FFFF, 32'd4294913295, 32'd4294913296};

		run_random(-5'sd12, 0);
		run_random(5'sd14, 54);
		run_random(5'($urandom_range(0, 31)), 0);
		run_random(-5'sd16, 18);
		run_random(5'sd15, 54);
		run_random(5'($urandom_range(0, 31)), 0);

		wait_drained();
		repeat (DrainCycles) @(posedge clk);

		$display("Converted %0d timestamps under %0d time-zone offsets, years %0d to %0d,",
			converted, tz_settings, year_lo, year_hi);
		$display("including wraparound at both ends of the 32-bit range and sender gaps.");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/esc_pkg.sv
src/epoch_seconds_to_calendar.sv
src/esc_checker.sv
tb/sv/tb_epoch_seconds_to_calendar.sv
